FILE: design/abam_pkg.sv
`default_nettype none

package abam_pkg;

	// default window length as a power of two and converter resolution
	localparam int unsigned LOG_WINDOW_DEF  = 6;
	localparam int unsigned SAMPLE_BITS_DEF = 12;

	// control from the handshake logic to the accumulator
	typedef struct packed {
		logic accept;     // an input beat is taken this cycle
		logic out_load;   // output register takes a new result
	} ctrl_t;

endpackage

`default_nettype wire

FILE: design/abam_cell.sv
`default_nettype none

// one tap of the sample delay line
module abam_cell #(
	parameter int unsigned SAMPLE_BITS = abam_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   shift,
	input  wire logic [SAMPLE_BITS-1:0] d,
	output logic      [SAMPLE_BITS-1:0] q
);

	logic [SAMPLE_BITS-1:0] tap_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

`default_nettype wire

FILE: design/abam_accum.sv
`default_nettype none

// running window sum, held average and output register
module abam_accum #(
	parameter int unsigned LOG_WINDOW  = abam_pkg::LOG_WINDOW_DEF,
	parameter int unsigned SAMPLE_BITS = abam_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire abam_pkg::ctrl_t        ctrl,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [SAMPLE_BITS-1:0] oldest,
	output logic      [SAMPLE_BITS-1:0] average,
	output logic      [SAMPLE_BITS-1:0] magnitude,
	output logic                        window_full
);

	localparam int unsigned SUM_W = SAMPLE_BITS + LOG_WINDOW;
	localparam logic [SAMPLE_BITS-1:0] MID = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [LOG_WINDOW-1:0]  LAST_POS = {LOG_WINDOW{1'b1}};

	logic [LOG_WINDOW-1:0]  pos_q;
	logic                   filled_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] held_q;

	logic                   filled_next;
	logic [SUM_W-1:0]       sum_next;
	logic [SAMPLE_BITS-1:0] held_next;
	logic [SAMPLE_BITS-1:0] mag_next;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   full_q;

	always_comb begin
		filled_next = filled_q | (pos_q == LAST_POS);
		// oldest tap only counts once the line holds a whole window
		sum_next = sum_q - (filled_q ? {{LOG_WINDOW{1'b0}}, oldest} : {SUM_W{1'b0}})
			+ {{LOG_WINDOW{1'b0}}, sample};
		held_next = filled_next ? sum_next[SUM_W-1 -: SAMPLE_BITS] : held_q;
		mag_next = (held_next >= MID) ? (held_next - MID) : (MID - held_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
			held_q   <= MID;
		end else if (ctrl.accept) begin
			pos_q    <= pos_q + 1'b1;
			filled_q <= filled_next;
			sum_q    <= sum_next;
			held_q   <= held_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			avg_q  <= held_next;
			mag_q  <= mag_next;
			full_q <= filled_next;
		end
	end

	assign average     = avg_q;
	assign magnitude   = mag_q;
	assign window_full = full_q;

endmodule

`default_nettype wire

FILE: design/adc_boxcar_average_magnitude.sv
`default_nettype none

// channel   dir  handshake              payload
// input     in   in_valid / in_stall    sample
// output    out  out_valid / out_stall  average, magnitude, window_full
//
// one beat per cycle while in_stall is low; a result follows in the next cycle
// the rate is set by the sum update (add new tap, drop oldest tap)
// reset clears position, fill flag and sum, sets the held average to midscale;
// the delay line keeps its taps, read only once a whole window has been written
// in_stall is raised only while a result waits and out_stall holds it

module adc_boxcar_average_magnitude #(
	parameter int unsigned LOG_WINDOW  = abam_pkg::LOG_WINDOW_DEF,
	parameter int unsigned SAMPLE_BITS = abam_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [SAMPLE_BITS-1:0] average,
	output logic      [SAMPLE_BITS-1:0] magnitude,
	output logic                        window_full
);

	localparam int unsigned TAPS = 1 << LOG_WINDOW;

	abam_pkg::ctrl_t        ctrl;
	logic                   out_valid_q;
	// tap_line[0] is the new sample, tap_line[TAPS] the one a window old
	logic [SAMPLE_BITS-1:0] tap_line [TAPS+1];

	// input is held off only while the output register is full and stalled
	assign in_stall      = out_valid_q & out_stall;
	assign ctrl.accept   = in_valid & ~in_stall;
	assign ctrl.out_load = ctrl.accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign tap_line[0] = sample;

	// delay line: every accepted beat moves each tap one cell along
	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		abam_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk  (clk),
			.shift(ctrl.accept),
			.d    (tap_line[i]),
			.q    (tap_line[i+1])
		);
	end

	abam_accum #(
		.LOG_WINDOW (LOG_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (sample),
		.oldest     (tap_line[TAPS]),
		.average    (average),
		.magnitude  (magnitude),
		.window_full(window_full)
	);

endmodule

`default_nettype wire

FILE: design/abam_checker.sv
`default_nettype none

module abam_checker #(
	parameter int unsigned SAMPLE_BITS = abam_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [SAMPLE_BITS-1:0] average,
	input wire logic [SAMPLE_BITS-1:0] magnitude,
	input wire logic                   window_full
);

	localparam logic [SAMPLE_BITS-1:0] MID = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	// input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no result waiting");

	// every accepted sample yields a result the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted beat produced no result");

	// once the window is full it stays full
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && window_full) |=> window_full)
		else $error("window full flag dropped");

	// before the first full window the average sits at midscale
	a_midscale: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_full) |-> (average == MID && magnitude == '0))
		else $error("average left midscale before window filled");

endmodule

bind adc_boxcar_average_magnitude abam_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_abam_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.average    (average),
	.magnitude  (magnitude),
	.window_full(window_full)
);

`default_nettype wire

FILE: tb/adc_boxcar_average_magnitude_tb.sv
`timescale 1ns / 100ps

module adc_boxcar_average_magnitude_tb;

	localparam int unsigned LW    = abam_pkg::LOG_WINDOW_DEF;
	localparam int unsigned SB    = abam_pkg::SAMPLE_BITS_DEF;
	localparam int unsigned DEPTH = 1 << LW;

	// converter midscale, the held average before the first full window
	localparam logic [SB-1:0] MIDSCALE = SB'(((1 << SB) - 1) >> 1);

	// hard stop far beyond the slowest legal run
	localparam int CYCLE_LIMIT = 200000;
	// registered output of the pipe plus margin, waited out after the last beat
	localparam int DRAIN_CYCLES = 8;
	// keep the log short if everything goes wrong
	localparam int PRINT_CAP = 50;

	// sample shapes for the random segments
	typedef enum int {
		MODE_UNIFORM,
		MODE_ALL_ZERO,
		MODE_FULL_SCALE,
		MODE_NEAR_MID,
		MODE_RAILS
	} stim_mode_t;

	typedef struct packed {
		logic [SB-1:0] average;
		logic [SB-1:0] magnitude;
		logic          window_full;
	} boxcar_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [SB-1:0] sample = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [SB-1:0] average;
	logic [SB-1:0] magnitude;
	logic          window_full;

	// samples waiting for the driver, expected results waiting for the monitor
	logic [SB-1:0]  sample_q [$];
	boxcar_result_t avg_expect_q [$];

	// idling knobs, written by the stimulus process on falling edges
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// long receiver hold-off, counted down by the monitor
	int unsigned hold_len = 0;

	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	// own copy of the filter state
	logic [SB-1:0]    model_ring [DEPTH];
	logic [LW-1:0]    model_pos;
	logic             model_full;
	logic [SB+LW-1:0] model_sum;
	logic [SB-1:0]    model_avg;

	// driver next-state scratch
	logic          drv_valid_nxt;
	logic [SB-1:0] drv_sample_nxt;

	adc_boxcar_average_magnitude u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.average     (average),
		.magnitude   (magnitude),
		.window_full (window_full)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ring contents are left alone: they are only read after being written
	task automatic clear_boxcar_model;
		model_pos  = '0;
		model_full = 1'b0;
		model_sum  = '0;
		model_avg  = MIDSCALE;
	endtask

	// advance the filter by one accepted sample and queue the result it gives
	task automatic track_boxcar(input logic [SB-1:0] s);
		boxcar_result_t r;
		// the oldest tap only leaves the sum once the window has wrapped
		if (model_full) begin
			model_sum = model_sum - model_ring[model_pos];
		end
		model_sum = model_sum + s;
		model_ring[model_pos] = s;
		// the sample that completes the first pass already updates the average
		if (model_pos == LW'(DEPTH - 1)) begin
			model_full = 1'b1;
		end
		model_pos = model_pos + 1'b1;
		if (model_full) begin
			model_avg = SB'(model_sum >> LW);
		end
		r.average     = model_avg;
		r.magnitude   = (model_avg >= MIDSCALE) ? model_avg - MIDSCALE : MIDSCALE - model_avg;
		r.window_full = model_full;
		avg_expect_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_cnt < PRINT_CAP) begin
			$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
				cycle_cnt);
		end
		mismatch_cnt++;
	endtask

	task automatic check_result;
		boxcar_result_t want;
		if (avg_expect_q.size() == 0) begin
			report_mismatch("beat with nothing expected, average", average, 0);
			return;
		end
		want = avg_expect_q.pop_front();
		if (average !== want.average) begin
			report_mismatch("average", average, want.average);
		end
		if (magnitude !== want.magnitude) begin
			report_mismatch("magnitude", magnitude, want.magnitude);
		end
		if (window_full !== want.window_full) begin
			report_mismatch("window_full", window_full, want.window_full);
		end
	endtask

	function automatic logic [SB-1:0] pick_sample(input stim_mode_t m);
		case (m)
			MODE_ALL_ZERO: begin
				return '0;
			end
			MODE_FULL_SCALE: begin
				return '1;
			end
			MODE_NEAR_MID: begin
				return SB'(MIDSCALE - 8 + $urandom_range(16));
			end
			MODE_RAILS: begin
				return $urandom_range(1) ? '1 : '0;
			end
			default: begin
				return SB'($urandom_range((1 << SB) - 1));
			end
		endcase
	endfunction

	// random segments of 16 to 90 samples; a constant run may be shorter than a window
	task automatic queue_random(input int n);
		int left;
		int seg;
		int pick;
		stim_mode_t m;
		left = n;
		while (left > 0) begin
			pick = $urandom_range(9);
			case (pick)
				5: m = MODE_NEAR_MID;
				6: m = MODE_ALL_ZERO;
				7: m = MODE_FULL_SCALE;
				8, 9: m = MODE_RAILS;
				default: m = MODE_UNIFORM;
			endcase
			seg = $urandom_range(90, 16);
			for (int i = 0; i < seg && left > 0; i++) begin
				sample_q.push_back(pick_sample(m));
				left--;
			end
		end
	endtask

	// sender pause: nothing queued, nothing offered, every result back
	task automatic wait_idle;
		while (sample_q.size() != 0 || in_valid || avg_expect_q.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// driver: hold the beat until taken, then maybe offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
			clear_boxcar_model();
		end else begin
			drv_valid_nxt  = in_valid;
			drv_sample_nxt = sample;
			if (in_valid && !in_stall) begin
				track_boxcar(sample);
				drv_valid_nxt = 1'b0;
			end
			// a new beat may go out in the same step the old one left, so valid can stay up
			if (!drv_valid_nxt && sample_q.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				drv_valid_nxt  = 1'b1;
				drv_sample_nxt = sample_q.pop_front();
			end
			in_valid <= drv_valid_nxt;
			sample   <= drv_sample_nxt;
		end
	end

	// monitor: check taken results, then choose the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (hold_len != 0) begin
				hold_len--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [SB-1:0] corner_samples [12];
		corner_samples = '{12'h000, 12'hFFF, 12'h7FF, 12'h800, 12'h001, 12'hFFE,
			12'hAAA, 12'h555, 12'h7FE, 12'h801, 12'hFFF, 12'h000};

		// single reset at the start
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// rails, midscale neighbors and alternating bit patterns, back to back
		foreach (corner_samples[i]) begin
			sample_q.push_back(corner_samples[i]);
		end
		wait_idle();

		// no idling; the first full window and the position wrap fall in here
		queue_random(80);
		wait_idle();

		// sender idles most cycles
		send_idle_pct = 64;
		queue_random(80);
		wait_idle();

		// receiver stalls most cycles
		send_idle_pct  = 0;
		recv_stall_pct = 64;
		queue_random(80);
		wait_idle();

		// both sides idle now and then
		send_idle_pct  = 24;
		recv_stall_pct = 24;
		queue_random(80);
		wait_idle();

		// long hold-off while the sender streams, so the input backs up
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len       = 150;
		queue_random(40);
		wait_idle();

		// mixed idling to close out
		send_idle_pct  = 24;
		recv_stall_pct = 24;
		queue_random(80);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
